### src/s2cfp_pkg.sv
// Package for the serial-to-CAN frame parser.
// Holds the parse phase type and the fixed framing constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s2cfp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_ADDR_HI = 3'd1,
        PH_ADDR_LO = 3'd2,
        PH_LEN     = 3'd3,
        PH_DATA    = 3'd4
    } t_phase;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MAX_BYTES  = 8;
    localparam int unsigned ID_W       = 11;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned PAYLOAD_W  = BYTE_W * MAX_BYTES;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h24;
    localparam logic [BYTE_W-1:0] MAX_LEN      = 8'd8;
    localparam logic [2:0]        ADDR_HI_MASK = 3'h7;

endpackage

`default_nettype wire

### src/serial_to_can_frame_parser.sv
// Top level of the serial-to-CAN frame parser: input register, phase machine, result register.
// Depends on s2cfp_pkg for the phase type and framing constants.
// The byte that completes a result passes the input register, then the result register sets o_out_valid.
// Throughput: one byte per cycle unless the output stalls; the input register and the result
// register are the only stages, and a byte leaves the input register unless the result register is stalled.
// Reset (synchronous, active low): hunting for the header, header byte 0x24, no item held.
`timescale 1ns / 1ps
`default_nettype none

module serial_to_can_frame_parser (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [s2cfp_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [s2cfp_pkg::ID_W-1:0]             o_frame_id,
    output logic [s2cfp_pkg::LEN_W-1:0]            o_frame_length,
    output logic [s2cfp_pkg::PAYLOAD_W-1:0]        o_frame_payload,
    output logic                                   o_length_error,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [s2cfp_pkg::BYTE_W-1:0]      i_cfg_data
);

    logic                                  r_in_valid;
    logic [s2cfp_pkg::BYTE_W-1:0]          r_in_byte;
    logic [s2cfp_pkg::BYTE_W-1:0]          r_header;

    s2cfp_pkg::t_phase                     r_phase, n_phase;
    logic [s2cfp_pkg::ID_W-1:0]            r_id, n_id;
    logic [s2cfp_pkg::LEN_W-1:0]           r_len, n_len;
    logic [s2cfp_pkg::LEN_W-1:0]           r_count, n_count;
    logic [s2cfp_pkg::PAYLOAD_W-1:0]       r_payload, n_payload;

    logic                                  r_out_valid, n_out_valid;
    logic [s2cfp_pkg::ID_W-1:0]            r_out_id, n_out_id;
    logic [s2cfp_pkg::LEN_W-1:0]           r_out_len, n_out_len;
    logic [s2cfp_pkg::PAYLOAD_W-1:0]       r_out_payload, n_out_payload;
    logic                                  r_out_err, n_out_err;

    logic                                  advance;
    logic                                  proc;
    logic [s2cfp_pkg::LEN_W-1:0]           count_inc;
    logic [s2cfp_pkg::PAYLOAD_W-1:0]       payload_ins;

    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_frame_id      = r_out_id;
    assign o_frame_length  = r_out_len;
    assign o_frame_payload = r_out_payload;
    assign o_length_error  = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= s2cfp_pkg::HEADER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_header <= i_cfg_data;
        end
    end

    assign count_inc = r_count + 4'd1;

    always_comb begin
        for (int k = 0; k < s2cfp_pkg::MAX_BYTES; k++) begin
            if (r_count[2:0] == 3'(k)) begin
                payload_ins[k*s2cfp_pkg::BYTE_W +: s2cfp_pkg::BYTE_W] = r_in_byte;
            end else begin
                payload_ins[k*s2cfp_pkg::BYTE_W +: s2cfp_pkg::BYTE_W] =
                    r_payload[k*s2cfp_pkg::BYTE_W +: s2cfp_pkg::BYTE_W];
            end
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_id          = r_id;
        n_len         = r_len;
        n_count       = r_count;
        n_payload     = r_payload;
        n_out_valid   = r_out_valid;
        n_out_id      = r_out_id;
        n_out_len     = r_out_len;
        n_out_payload = r_out_payload;
        n_out_err     = r_out_err;
        if (advance) begin
            n_out_valid = 1'b0;
        end
        if (proc) begin
            case (r_phase)
                s2cfp_pkg::PH_ADDR_HI: begin
                    n_id    = {r_in_byte[2:0] & s2cfp_pkg::ADDR_HI_MASK, 8'h00};
                    n_phase = s2cfp_pkg::PH_ADDR_LO;
                end
                s2cfp_pkg::PH_ADDR_LO: begin
                    n_id    = {r_id[10:8], r_id[7:0] | r_in_byte};
                    n_phase = s2cfp_pkg::PH_LEN;
                end
                s2cfp_pkg::PH_LEN: begin
                    if (r_in_byte == 8'd0) begin
                        n_phase = s2cfp_pkg::PH_HUNT;
                    end else if (r_in_byte > s2cfp_pkg::MAX_LEN) begin
                        n_phase       = s2cfp_pkg::PH_HUNT;
                        n_out_valid   = 1'b1;
                        n_out_id      = r_id;
                        n_out_len     = '0;
                        n_out_payload = '0;
                        n_out_err     = 1'b1;
                    end else begin
                        n_len     = r_in_byte[s2cfp_pkg::LEN_W-1:0];
                        n_count   = '0;
                        n_payload = '0;
                        n_phase   = s2cfp_pkg::PH_DATA;
                    end
                end
                s2cfp_pkg::PH_DATA: begin
                    n_payload = payload_ins;
                    n_count   = count_inc;
                    if (count_inc >= r_len) begin
                        n_phase       = s2cfp_pkg::PH_HUNT;
                        n_count       = '0;
                        n_out_valid   = 1'b1;
                        n_out_id      = r_id;
                        n_out_len     = r_len;
                        n_out_payload = payload_ins;
                        n_out_err     = 1'b0;
                    end
                end
                default: begin
                    n_phase = (r_in_byte == r_header) ? s2cfp_pkg::PH_ADDR_HI
                                                      : s2cfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= s2cfp_pkg::PH_HUNT;
            r_id        <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_id        <= n_id;
            r_len       <= n_len;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_payload     <= n_payload;
        r_out_id      <= n_out_id;
        r_out_len     <= n_out_len;
        r_out_payload <= n_out_payload;
        r_out_err     <= n_out_err;
    end

`ifndef SYNTH
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_len == '0 && r_out_payload == '0))
        else $error("length error item carries data");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_err) |-> (r_out_len != '0 && r_out_len <= 4'd8))
        else $error("frame item length out of range");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == s2cfp_pkg::PH_DATA) |-> (r_count < r_len && r_len <= 4'd8))
        else $error("data byte count past frame length");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled with result register free");

    a_result_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_out_valid) |=> (r_phase == s2cfp_pkg::PH_HUNT))
        else $error("result emitted without return to hunting");
`endif

endmodule

`default_nettype wire

### sim/s2cfp_frame_check.sv
// Frame checker for the serial-to-CAN frame parser: watches the byte, config and frame channels,
// predicts each frame from the accepted bytes and compares it field by field.
// Depends on s2cfp_pkg for the widths, phase type and framing constants.
`timescale 1ns / 1ps

module s2cfp_frame_check
    import s2cfp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [ID_W-1:0]      i_frame_id,
    input  wire logic [LEN_W-1:0]     i_frame_length,
    input  wire logic [PAYLOAD_W-1:0] i_frame_payload,
    input  wire logic                 i_length_error,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_frames,
    output int                        o_len_errors
);

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
        logic                 err;
    } t_can_frame;

    t_can_frame           frame_q[$];
    logic [BYTE_W-1:0]    header;
    t_phase               phase;
    logic [ID_W-1:0]      id_acc;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     byte_cnt;
    logic [PAYLOAD_W-1:0] payload_acc;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_frames     = 0;
        o_len_errors = 0;
    end

    task report_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("MISMATCH at %0t ns: %s expected %0h got %0h", $time, what, want, got);
        o_fail_count++;
    endtask

    task parse_byte(input logic [BYTE_W-1:0] b);
        t_can_frame f;
        case (phase)
            PH_ADDR_HI: begin
                id_acc = {b[2:0] & ADDR_HI_MASK, 8'h00};
                phase  = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
                id_acc = id_acc | {3'b000, b};
                phase  = PH_LEN;
            end
            PH_LEN: begin
                if (b == '0) begin
                    phase = PH_HUNT;
                end else if (b > MAX_LEN) begin
                    phase     = PH_HUNT;
                    f.id      = id_acc;
                    f.len     = '0;
                    f.payload = '0;
                    f.err     = 1'b1;
                    frame_q.push_back(f);
                end else begin
                    len_reg     = b[LEN_W-1:0];
                    byte_cnt    = '0;
                    payload_acc = '0;
                    phase       = PH_DATA;
                end
            end
            PH_DATA: begin
                payload_acc = payload_acc | (PAYLOAD_W'(b) << {byte_cnt[2:0], 3'b000});
                byte_cnt    = byte_cnt + 1'b1;
                if (byte_cnt >= len_reg) begin
                    phase     = PH_HUNT;
                    f.id      = id_acc;
                    f.len     = len_reg;
                    f.payload = payload_acc;
                    f.err     = 1'b0;
                    frame_q.push_back(f);
                    byte_cnt  = '0;
                end
            end
            default: begin
                phase = (b == header) ? PH_ADDR_HI : PH_HUNT;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_can_frame want;
        if (!i_rst_n) begin
            frame_q.delete();
            header      = HEADER_RESET;
            phase       = PH_HUNT;
            id_acc      = '0;
            len_reg     = '0;
            byte_cnt    = '0;
            payload_acc = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frame_q.size() == 0) begin
                    report_mismatch("frame with none pending, frame_id", '0, i_frame_id);
                end else begin
                    want = frame_q.pop_front();
                    if (i_frame_id !== want.id)
                        report_mismatch("frame_id", want.id, i_frame_id);
                    if (i_frame_length !== want.len)
                        report_mismatch("frame_length", want.len, i_frame_length);
                    if (i_frame_payload !== want.payload)
                        report_mismatch("frame_payload", want.payload, i_frame_payload);
                    if (i_length_error !== want.err)
                        report_mismatch("length_error", want.err, i_length_error);
                    if (want.err)
                        o_len_errors++;
                    else
                        o_frames++;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                header = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                parse_byte(i_rx_byte);
        end
        o_pending <= frame_q.size();
    end

endmodule

### sim/testbench.sv
// Top of the serial-to-CAN frame parser testbench: clock, reset, byte stimulus, config writes,
// output stalls and the verdict. Depends on s2cfp_pkg, the parser and s2cfp_frame_check.
`timescale 1ns / 1ps

module testbench;
    import s2cfp_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [ID_W-1:0]      o_frame_id;
    logic [LEN_W-1:0]     o_frame_length;
    logic [PAYLOAD_W-1:0] o_frame_payload;
    logic                 o_length_error;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [BYTE_W-1:0]    i_cfg_data;

    int                   fail_count;
    int                   pending;
    int                   frames_done;
    int                   len_errors;
    int                   send_idle_pct;
    int                   stall_pct;
    int                   frame_bytes;
    logic                 hold_req;
    logic [BYTE_W-1:0]    header;

    logic [BYTE_W-1:0] directed_bytes[] = '{
        8'h55,
        HEADER_RESET, 8'hFF, 8'hFF, 8'h08,
        8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE,
        HEADER_RESET, 8'h00, 8'h00, 8'h00,
        HEADER_RESET, 8'hF8, 8'h00, 8'h09,
        HEADER_RESET, 8'h03, 8'h21, 8'h01, 8'h00
    };

    serial_to_can_frame_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_frame_id      (o_frame_id),
        .o_frame_length  (o_frame_length),
        .o_frame_payload (o_frame_payload),
        .o_length_error  (o_length_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    s2cfp_frame_check i_frame_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_frame_id      (o_frame_id),
        .i_frame_length  (o_frame_length),
        .i_frame_payload (o_frame_payload),
        .i_length_error  (o_length_error),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_frames        (frames_done),
        .o_len_errors    (len_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off whenever hold_req toggles
    initial begin : receiver
        logic hold_seen;
        int   hold_left;
        hold_seen   = 1'b0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req !== hold_seen) begin
                hold_seen = hold_req;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_rx_byte  <= BYTE_W'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task wait_drain;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task write_header(input logic [BYTE_W-1:0] v);
        wait_drain();
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        header = v;
    endtask

    task send_can_frame(input int len);
        send_byte(header);
        send_byte(BYTE_W'($urandom));
        send_byte(BYTE_W'($urandom));
        send_byte(BYTE_W'(len));
        frame_bytes += 4;
        if (len >= 1 && len <= MAX_LEN) begin
            for (int i = 0; i < len; i++) begin
                send_byte(($urandom_range(0, 9) == 0) ? header : BYTE_W'($urandom));
                frame_bytes++;
            end
        end
    endtask

    task send_random_frame;
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(($urandom_range(0, 3) == 0) ? header : BYTE_W'($urandom));
        end else if (kind < 14) begin
            // truncated frame: the next header lands inside it
            n = $urandom_range(0, 3);
            send_byte(header);
            frame_bytes++;
            repeat (n) begin
                send_byte(BYTE_W'($urandom));
                frame_bytes++;
            end
        end else if (kind < 20) begin
            send_can_frame(0);
        end else if (kind < 30) begin
            send_can_frame($urandom_range(MAX_LEN + 1, 255));
        end else begin
            send_can_frame($urandom_range(1, MAX_LEN));
        end
    endtask

    initial begin : stimulus
        int start;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_rx_byte     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        hold_req      = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        frame_bytes   = 0;
        header        = HEADER_RESET;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_header(8'h00);
                1: write_header(8'hFF);
                default: write_header(BYTE_W'($urandom));
            endcase
            send_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 33 : 0;
            stall_pct     = (ph == 2) ? 46 : (ph == 3) ? 33 : 0;
            if (ph == 0) begin
                // fill the block while the output is held off, then drain
                hold_req = ~hold_req;
                repeat (8) send_can_frame(1);
                wait_drain();
            end
            start = frame_bytes;
            while (frame_bytes - start < 300) begin
                send_random_frame();
                if ($urandom_range(0, 39) == 0)
                    wait_drain();
            end
        end

        wait_drain();
        repeat (10) @(negedge i_clk);
        $display("Sent %0d frame bytes under the reset header and four written headers,",
                 frame_bytes);
        $display("four idle mixes and a long output hold-off; %0d frames, %0d length errors.",
                 frames_done, len_errors);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
